>>> src/kdq_pkg.sv
package kdq_pkg;

  localparam int ROWS_DEF           = 4;
  localparam int COLS_DEF           = 4;
  localparam int QUEUE_DEPTH_DEF    = 16;
  localparam int STABLE_SAMPLES_DEF = 3;

  localparam int DEBOUNCE_W   = 10;
  localparam int LONG_PRESS_W = 14;
  localparam int CFG_DATA_W   = 14;
  localparam int CFG_IDX_W    = 2;
  localparam int MASK_W       = 16;
  localparam int LEVEL_W      = 5;
  localparam int TIME_W       = 32;
  localparam int CNT_W        = 4;

  localparam logic [DEBOUNCE_W-1:0]   DEBOUNCE_RST   = 10'd20;
  localparam logic [DEBOUNCE_W-1:0]   DEBOUNCE_MAX   = 10'd1000;
  localparam logic [LONG_PRESS_W-1:0] LONG_PRESS_RST = 14'd1000;
  localparam logic [LONG_PRESS_W-1:0] LONG_PRESS_MIN = 14'd100;
  localparam logic [LONG_PRESS_W-1:0] LONG_PRESS_MAX = 14'd10000;
  localparam logic [CNT_W-1:0]        SAMPLE_CNT_MAX = 4'd15;

  localparam logic ACT_SAMPLE = 1'b0;
  localparam logic ACT_POP    = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DEBOUNCE   = 2'd0,
    REG_LONG_PRESS = 2'd1
  } reg_idx_t;

  typedef enum logic [1:0] {
    KS_RELEASED = 2'd0,
    KS_PRESSED  = 2'd1,
    KS_LONG     = 2'd2
  } kstate_t;

  typedef struct packed {
    logic              action;
    logic [1:0]        key_row;
    logic [1:0]        key_col;
    logic              level_pressed;
    logic [TIME_W-1:0] now_ms;
  } in_t;

  typedef struct packed {
    logic               event_valid;
    logic [1:0]         event_row;
    logic [1:0]         event_col;
    logic [1:0]         event_state;
    logic [1:0]         event_prev_state;
    logic [MASK_W-1:0]  key_mask;
    logic [LEVEL_W-1:0] queue_level;
  } out_t;

  typedef struct packed {
    logic [1:0] row;
    logic [1:0] col;
    kstate_t    state;
    kstate_t    prev;
  } event_t;

  typedef struct packed {
    kstate_t           state;
    kstate_t           prev;
    logic              pending;
    logic [CNT_W-1:0]  stable;
    logic [TIME_W-1:0] db_start;
    logic [TIME_W-1:0] press_start;
  } key_ent_t;

  typedef struct packed {
    logic push;
    logic pop;
  } q_req_t;

  typedef struct packed {
    logic               hit;
    logic [LEVEL_W-1:0] level;
  } q_sts_t;

endpackage

>>> src/kdq_queue.sv
module kdq_queue
  import kdq_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic   clk,
  input  logic   rst_n,
  input  q_req_t req,
  input  event_t push_ev,
  output q_sts_t sts,
  output event_t rd_ev
);

  localparam int PW = $clog2(QUEUE_DEPTH);
  localparam int FW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PW-1:0] PTR_LAST = PW'(QUEUE_DEPTH - 1);
  localparam logic [FW-1:0] FILL_FULL = FW'(QUEUE_DEPTH);

  event_t        mem [QUEUE_DEPTH];
  event_t        rd_ev_r;
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [FW-1:0] fill_r, fill_nxt;
  logic          full;
  logic          hit;

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    return (p == PTR_LAST) ? '0 : p + PW'(1);
  endfunction

  assign full = (fill_r == FILL_FULL);
  assign hit  = req.pop && (fill_r != '0);

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    fill_nxt   = fill_r;
    if (req.push) begin
      wr_ptr_nxt = ptr_inc(wr_ptr_r);
      if (full) begin
        rd_ptr_nxt = ptr_inc(rd_ptr_r);
      end else begin
        fill_nxt = fill_r + FW'(1);
      end
    end else if (hit) begin
      rd_ptr_nxt = ptr_inc(rd_ptr_r);
      fill_nxt   = fill_r - FW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (req.push) begin
      mem[wr_ptr_r] <= push_ev;
    end
    if (hit) begin
      rd_ev_r <= mem[rd_ptr_r];
    end
  end

  assign sts.hit   = hit;
  assign sts.level = LEVEL_W'(fill_nxt);
  assign rd_ev     = rd_ev_r;

endmodule

>>> src/keypad_debounce_event_queue.sv
// Channel | Direction | Handshake          | Word
// in_     | input     | in_valid/in_stall   | in_t: action, key, level, timestamp
// out_    | output    | out_valid/out_stall | out_t: popped event, key mask, queue level
// cfg_    | input     | cfg_valid/cfg_ready | cfg_index, cfg_data (ready always high)
//
// Three-stage flow: key entry read, update and write back, output register.
// out_valid is s2_v_r: it rises when the word moves from s1 into the output register.
// One word per cycle sustained while out_stall is low; the key memory read-modify-write
// and its forwarding path set that figure.
// Synchronous reset clears key valid bits, pressed mask, queue pointers and pipeline.
// out_stall with both stages full holds both words and raises in_stall in the same cycle.
module keypad_debounce_event_queue
  import kdq_pkg::*;
#(
  parameter int ROWS           = ROWS_DEF,
  parameter int COLS           = COLS_DEF,
  parameter int QUEUE_DEPTH    = QUEUE_DEPTH_DEF,
  parameter int STABLE_SAMPLES = STABLE_SAMPLES_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_t                   in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_t                  out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int NKEYS = ROWS * COLS;
  localparam int KW    = (NKEYS > 1) ? $clog2(NKEYS) : 1;
  localparam logic [CNT_W-1:0] STABLE_REQ = CNT_W'(STABLE_SAMPLES);

  logic [DEBOUNCE_W-1:0]   debounce_r;
  logic [LONG_PRESS_W-1:0] long_press_r;

  key_ent_t          key_mem [NKEYS];
  logic [NKEYS-1:0]  kvalid_r;
  logic [NKEYS-1:0]  pressed_r, pressed_nxt;

  logic              in_acc;
  logic              in_range;
  logic [KW-1:0]     raddr;

  logic              s1_v_r;
  in_t               s1_r;
  logic              s1_inr_r;
  logic [KW-1:0]     s1_k_r;
  key_ent_t          krd_r;
  logic              kvld_rd_r;
  logic              fwd_r;
  key_ent_t          fwd_ent_r;
  logic              s1_adv;

  key_ent_t          ent, nent;
  kstate_t           ns;
  logic              chg;
  logic              held;
  logic [TIME_W-1:0] db_diff, lp_diff;
  logic              wr;

  q_req_t            q_req;
  q_sts_t            q_sts;
  event_t            push_ev;
  event_t            rd_ev;

  logic              s2_v_r;
  logic              s2_hit_r;
  logic [MASK_W-1:0] s2_mask_r, mask_nxt;
  logic [LEVEL_W-1:0] s2_lvl_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      debounce_r   <= DEBOUNCE_RST;
      long_press_r <= LONG_PRESS_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_DEBOUNCE: begin
          if (cfg_data[DEBOUNCE_W-1:0] <= DEBOUNCE_MAX) begin
            debounce_r <= cfg_data[DEBOUNCE_W-1:0];
          end
        end
        REG_LONG_PRESS: begin
          if (cfg_data >= LONG_PRESS_MIN && cfg_data <= LONG_PRESS_MAX) begin
            long_press_r <= cfg_data;
          end
        end
        default: ;
      endcase
    end
  end

  // accept and key memory read
  assign in_range = (int'(in_data.key_row) < ROWS) && (int'(in_data.key_col) < COLS);
  assign raddr    = in_range ? KW'(int'(in_data.key_row) * COLS + int'(in_data.key_col))
                             : '0;
  assign s1_adv   = s1_v_r && (!s2_v_r || !out_stall);
  assign in_stall = s1_v_r && !s1_adv;
  assign in_acc   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_acc) begin
      s1_v_r <= 1'b1;
    end else if (s1_adv) begin
      s1_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_r      <= in_data;
      s1_inr_r  <= in_range;
      s1_k_r    <= raddr;
      krd_r     <= key_mem[raddr];
      kvld_rd_r <= kvalid_r[raddr];
      fwd_r     <= wr && (s1_k_r == raddr);
      fwd_ent_r <= nent;
    end
    if (wr) begin
      key_mem[s1_k_r] <= nent;
    end
  end

  // update stage
  always_comb begin
    ent     = fwd_r ? fwd_ent_r : (kvld_rd_r ? krd_r : key_ent_t'('0));
    nent    = ent;
    ns      = ent.state;
    chg     = 1'b0;
    held    = (ent.state != KS_RELEASED);
    db_diff = ent.pending ? s1_r.now_ms - ent.db_start : '0;
    lp_diff = s1_r.now_ms - ent.press_start;
    if (s1_r.level_pressed == held) begin
      nent.pending = 1'b0;
      nent.stable  = '0;
    end else begin
      if (!ent.pending) begin
        nent.pending  = 1'b1;
        nent.db_start = s1_r.now_ms;
        nent.stable   = CNT_W'(1);
      end else if (ent.stable < SAMPLE_CNT_MAX) begin
        nent.stable = ent.stable + CNT_W'(1);
      end
      if (nent.stable >= STABLE_REQ && db_diff >= TIME_W'(debounce_r)) begin
        nent.pending = 1'b0;
        nent.stable  = '0;
        chg          = 1'b1;
        if (s1_r.level_pressed) begin
          nent.press_start = s1_r.now_ms;
          ns               = KS_PRESSED;
        end else begin
          ns = KS_RELEASED;
        end
      end
    end
    if (s1_r.level_pressed && !chg && ent.state == KS_PRESSED &&
        lp_diff >= TIME_W'(long_press_r)) begin
      chg = 1'b1;
      ns  = KS_LONG;
    end
    if (chg) begin
      nent.prev  = ent.state;
      nent.state = ns;
    end
  end

  assign wr = s1_adv && (s1_r.action == ACT_SAMPLE) && s1_inr_r;

  assign push_ev.row   = s1_r.key_row;
  assign push_ev.col   = s1_r.key_col;
  assign push_ev.state = nent.state;
  assign push_ev.prev  = nent.prev;
  assign q_req.push    = wr && chg;
  assign q_req.pop     = s1_adv && (s1_r.action == ACT_POP);

  always_comb begin
    pressed_nxt = pressed_r;
    if (wr) begin
      pressed_nxt[s1_k_r] = (nent.state != KS_RELEASED);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kvalid_r  <= '0;
      pressed_r <= '0;
    end else begin
      pressed_r <= pressed_nxt;
      if (wr) begin
        kvalid_r[s1_k_r] <= 1'b1;
      end
    end
  end

  for (genvar i = 0; i < MASK_W; i++) begin : g_mask
    if (i < NKEYS) begin : g_key
      assign mask_nxt[i] = pressed_nxt[i];
    end else begin : g_none
      assign mask_nxt[i] = 1'b0;
    end
  end

  kdq_queue #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .req    (q_req),
    .push_ev(push_ev),
    .sts    (q_sts),
    .rd_ev  (rd_ev)
  );

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (s1_adv) begin
      s2_v_r <= 1'b1;
    end else if (!out_stall) begin
      s2_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      s2_hit_r  <= q_sts.hit;
      s2_mask_r <= mask_nxt;
      s2_lvl_r  <= q_sts.level;
    end
  end

  assign out_valid                 = s2_v_r;
  assign out_data.event_valid      = s2_hit_r;
  assign out_data.event_row        = s2_hit_r ? rd_ev.row : 2'd0;
  assign out_data.event_col        = s2_hit_r ? rd_ev.col : 2'd0;
  assign out_data.event_state      = s2_hit_r ? rd_ev.state : KS_RELEASED;
  assign out_data.event_prev_state = s2_hit_r ? rd_ev.prev : KS_RELEASED;
  assign out_data.key_mask         = s2_mask_r;
  assign out_data.queue_level      = s2_lvl_r;

endmodule

>>> src/kdq_checker.sv
module kdq_checker
  import kdq_pkg::*;
(
  input logic clk,
  input logic rst_n,
  input logic out_valid,
  input logic out_stall,
  input out_t out_data
);

  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("out_valid high after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled output word changed");

  a_event_changes: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.event_valid |->
      out_data.event_state != out_data.event_prev_state)
    else $error("popped event without a state change");

  a_long_from_pressed: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.event_valid && out_data.event_state == KS_LONG |->
      out_data.event_prev_state == KS_PRESSED)
    else $error("long press event not preceded by press");

  a_empty_event_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.event_valid |->
      out_data.event_row == 2'd0 && out_data.event_col == 2'd0 &&
      out_data.event_state == KS_RELEASED && out_data.event_prev_state == KS_RELEASED)
    else $error("event fields not cleared without a popped event");

endmodule

bind keypad_debounce_event_queue kdq_checker u_kdq_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .out_valid(out_valid),
  .out_stall(out_stall),
  .out_data (out_data)
);

>>> tb/tb.sv
module tb;
  import kdq_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;
  localparam int NUM_KEYS    = ROWS_DEF * COLS_DEF;
  localparam int PTR_W       = $clog2(QUEUE_DEPTH_DEF);
  localparam int NUM_PHASES  = 8;
  localparam int PHASE_WORDS = 216;
  localparam int HOLD_PHASE  = 2;
  localparam int HOLD_CYCLES = 300;

  typedef struct packed {
    in_t  word;
    logic typed;
    out_t want;
  } dir_row_t;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  in_t                   in_data;
  logic                  out_valid;
  logic                  out_stall;
  out_t                  out_data;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  keypad_debounce_event_queue uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  kstate_t                 key_st   [NUM_KEYS];
  kstate_t                 key_prev [NUM_KEYS];
  logic                    db_pend  [NUM_KEYS];
  logic [TIME_W-1:0]       db_t0    [NUM_KEYS];
  logic [CNT_W-1:0]        db_cnt   [NUM_KEYS];
  logic [TIME_W-1:0]       press_t0 [NUM_KEYS];
  event_t                  evq      [QUEUE_DEPTH_DEF];
  logic [PTR_W-1:0]        wr_ptr;
  logic [PTR_W-1:0]        rd_ptr;
  logic [LEVEL_W-1:0]      ev_fill;
  logic [DEBOUNCE_W-1:0]   db_ms;
  logic [LONG_PRESS_W-1:0] lp_ms;

  out_t due_words[$];
  int   err_cnt  = 0;
  int   snd_pct  = 0;
  int   rcv_pct  = 0;
  int   phase_no = -1;

  task automatic model_reset();
    for (int i = 0; i < NUM_KEYS; i++) begin
      key_st[i]   = KS_RELEASED;
      key_prev[i] = KS_RELEASED;
      db_pend[i]  = 1'b0;
      db_t0[i]    = '0;
      db_cnt[i]   = '0;
      press_t0[i] = '0;
    end
    wr_ptr  = '0;
    rd_ptr  = '0;
    ev_fill = '0;
    db_ms   = DEBOUNCE_RST;
    lp_ms   = LONG_PRESS_RST;
  endtask

  task automatic model_config(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    if (idx == REG_DEBOUNCE) begin
      if (val[DEBOUNCE_W-1:0] <= DEBOUNCE_MAX) db_ms = val[DEBOUNCE_W-1:0];
    end else if (idx == REG_LONG_PRESS) begin
      if (val >= LONG_PRESS_MIN && val <= LONG_PRESS_MAX) lp_ms = val;
    end
  endtask

  // record a state change as a queued event; drop the oldest event when the queue is full
  task automatic set_state(input logic [3:0] k, input kstate_t ns);
    if (ev_fill >= QUEUE_DEPTH_DEF) begin
      rd_ptr  = rd_ptr + 1'b1;
      ev_fill = ev_fill - 1'b1;
    end
    key_prev[k] = key_st[k];
    key_st[k]   = ns;
    evq[wr_ptr].row   = k[3:2];
    evq[wr_ptr].col   = k[1:0];
    evq[wr_ptr].state = key_st[k];
    evq[wr_ptr].prev  = key_prev[k];
    wr_ptr  = wr_ptr + 1'b1;
    ev_fill = ev_fill + 1'b1;
  endtask

  task automatic debounce_step(input in_t w, output out_t r);
    logic [3:0]        k;
    logic              held;
    logic [TIME_W-1:0] dt;
    event_t            e;
    r = '0;
    if (w.action == ACT_POP) begin
      if (ev_fill != 0) begin
        e = evq[rd_ptr];
        r.event_valid      = 1'b1;
        r.event_row        = e.row;
        r.event_col        = e.col;
        r.event_state      = e.state;
        r.event_prev_state = e.prev;
        rd_ptr  = rd_ptr + 1'b1;
        ev_fill = ev_fill - 1'b1;
      end
    end else begin
      k    = {w.key_row, w.key_col};
      held = key_st[k] != KS_RELEASED;
      if (w.level_pressed == held) begin
        db_pend[k] = 1'b0;
        db_cnt[k]  = '0;
      end else begin
        if (!db_pend[k]) begin
          db_pend[k] = 1'b1;
          db_t0[k]   = w.now_ms;
          db_cnt[k]  = 4'd1;
        end else if (db_cnt[k] < SAMPLE_CNT_MAX) begin
          db_cnt[k] = db_cnt[k] + 1'b1;
        end
        dt = w.now_ms - db_t0[k];
        if (db_cnt[k] >= STABLE_SAMPLES_DEF && dt >= db_ms) begin
          db_pend[k] = 1'b0;
          db_cnt[k]  = '0;
          if (w.level_pressed) begin
            press_t0[k] = w.now_ms;
            set_state(k, KS_PRESSED);
          end else begin
            set_state(k, KS_RELEASED);
          end
        end
      end
      dt = w.now_ms - press_t0[k];
      if (w.level_pressed && key_st[k] == KS_PRESSED && dt >= lp_ms) set_state(k, KS_LONG);
    end
    for (int i = 0; i < NUM_KEYS; i++) r.key_mask[i] = key_st[i] != KS_RELEASED;
    r.queue_level = ev_fill;
  endtask

  task automatic check_word(input out_t got);
    out_t want;
    if (due_words.size() == 0) begin
      $display("%0t: unexpected word, expected none, actual %h", $time, got);
      err_cnt++;
    end else begin
      want = due_words.pop_front();
      if (got.event_valid !== want.event_valid) begin
        $display("%0t: event_valid expected %0d actual %0d", $time, want.event_valid,
                 got.event_valid);
        err_cnt++;
      end
      if (got.event_row !== want.event_row) begin
        $display("%0t: event_row expected %0d actual %0d", $time, want.event_row, got.event_row);
        err_cnt++;
      end
      if (got.event_col !== want.event_col) begin
        $display("%0t: event_col expected %0d actual %0d", $time, want.event_col, got.event_col);
        err_cnt++;
      end
      if (got.event_state !== want.event_state) begin
        $display("%0t: event_state expected %0d actual %0d", $time, want.event_state,
                 got.event_state);
        err_cnt++;
      end
      if (got.event_prev_state !== want.event_prev_state) begin
        $display("%0t: event_prev_state expected %0d actual %0d", $time,
                 want.event_prev_state, got.event_prev_state);
        err_cnt++;
      end
      if (got.key_mask !== want.key_mask) begin
        $display("%0t: key_mask expected %h actual %h", $time, want.key_mask,
                 got.key_mask);
        err_cnt++;
      end
      if (got.queue_level !== want.queue_level) begin
        $display("%0t: queue_level expected %0d actual %0d", $time, want.queue_level,
                 got.queue_level);
        err_cnt++;
      end
    end
  endtask

  task automatic send_word(input in_t w, output out_t r);
    while ($urandom_range(0, 99) < snd_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (in_stall);
    debounce_step(w, r);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    model_config(idx, val);
  endtask

  task automatic wait_drained();
    do @(posedge clk); while (due_words.size() != 0);
  endtask

  function automatic out_t no_event(input logic [MASK_W-1:0] m, input logic [LEVEL_W-1:0] l);
    out_t o;
    o = '0;
    o.key_mask    = m;
    o.queue_level = l;
    return o;
  endfunction

  function automatic dir_row_t dir_entry(input logic act, input logic [1:0] row,
                                         input logic [1:0] col, input logic lvl,
                                         input logic [TIME_W-1:0] now, input logic typed,
                                         input out_t want);
    dir_row_t d;
    d.word.action        = act;
    d.word.key_row       = row;
    d.word.key_col       = col;
    d.word.level_pressed = lvl;
    d.word.now_ms        = now;
    d.typed              = typed;
    d.want               = want;
    return d;
  endfunction

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #4000000;
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    int hold_left;
    bit held_once;
    hold_left = 0;
    held_once = 0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) check_word(out_data);
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else if (phase_no == HOLD_PHASE && !held_once) begin
        held_once = 1;
        hold_left = HOLD_CYCLES - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= $urandom_range(0, 99) < rcv_pct;
      end
    end
  end

  initial begin
    dir_row_t          dir_tab[$];
    in_t               w;
    out_t              p;
    int                n, r, len, step_max, pop_pct;
    logic [3:0]        kk;
    logic              lvl;
    logic [TIME_W-1:0] t;

    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_data   <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;
    model_reset();
    t = '0;

    dir_tab.push_back(dir_entry(ACT_POP,    2'd0, 2'd0, 1'b0, 32'd0, 1'b1, no_event(16'h0, 5'd0)));
    dir_tab.push_back(dir_entry(ACT_SAMPLE, 2'd3, 2'd3, 1'b1, 32'd0, 1'b1, no_event(16'h0, 5'd0)));
    dir_tab.push_back(dir_entry(ACT_SAMPLE, 2'd3, 2'd3, 1'b1, 32'd10, 1'b1, no_event(16'h0, 5'd0)));
    dir_tab.push_back(dir_entry(ACT_SAMPLE, 2'd3, 2'd3, 1'b1, 32'd20, 1'b1,
                                no_event(16'h8000, 5'd1)));
    dir_tab.push_back(dir_entry(ACT_SAMPLE, 2'd3, 2'd3, 1'b1, 32'hFFFF_FFFF, 1'b0, '0));
    dir_tab.push_back(dir_entry(ACT_POP,    2'd3, 2'd3, 1'b1, 32'hFFFF_FFFF, 1'b0, '0));
    dir_tab.push_back(dir_entry(ACT_POP,    2'd0, 2'd0, 1'b0, 32'd0, 1'b0, '0));
    dir_tab.push_back(dir_entry(ACT_POP,    2'd0, 2'd0, 1'b0, 32'd0, 1'b1,
                                no_event(16'h8000, 5'd0)));
    dir_tab.push_back(dir_entry(ACT_SAMPLE, 2'd0, 2'd0, 1'b1, 32'd100, 1'b1,
                                no_event(16'h8000, 5'd0)));
    dir_tab.push_back(dir_entry(ACT_SAMPLE, 2'd0, 2'd0, 1'b0, 32'd105, 1'b1,
                                no_event(16'h8000, 5'd0)));
    dir_tab.push_back(dir_entry(ACT_SAMPLE, 2'd0, 2'd0, 1'b1, 32'd110, 1'b0, '0));
    dir_tab.push_back(dir_entry(ACT_SAMPLE, 2'd0, 2'd0, 1'b1, 32'd120, 1'b0, '0));
    dir_tab.push_back(dir_entry(ACT_SAMPLE, 2'd0, 2'd0, 1'b1, 32'd129, 1'b0, '0));
    dir_tab.push_back(dir_entry(ACT_SAMPLE, 2'd0, 2'd0, 1'b1, 32'd130, 1'b0, '0));
    dir_tab.push_back(dir_entry(ACT_SAMPLE, 2'd3, 2'd3, 1'b0, 32'd1000, 1'b0, '0));
    dir_tab.push_back(dir_entry(ACT_SAMPLE, 2'd3, 2'd3, 1'b0, 32'd1010, 1'b0, '0));
    dir_tab.push_back(dir_entry(ACT_SAMPLE, 2'd3, 2'd3, 1'b0, 32'd1020, 1'b0, '0));
    dir_tab.push_back(dir_entry(ACT_SAMPLE, 2'd1, 2'd2, 1'b1, 32'd1030, 1'b0, '0));
    dir_tab.push_back(dir_entry(ACT_POP,    2'd2, 2'd1, 1'b0, 32'd0, 1'b0, '0));
    dir_tab.push_back(dir_entry(ACT_POP,    2'd1, 2'd2, 1'b1, 32'h5555_AAAA, 1'b0, '0));
    dir_tab.push_back(dir_entry(ACT_POP,    2'd0, 2'd0, 1'b0, 32'd0, 1'b1,
                                no_event(16'h0001, 5'd0)));
    dir_tab.push_back(dir_entry(ACT_SAMPLE, 2'd2, 2'd1, 1'b1, 32'd0, 1'b1,
                                no_event(16'h0001, 5'd0)));

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_tab[i]) begin
      send_word(dir_tab[i].word, p);
      due_words.push_back(dir_tab[i].typed ? dir_tab[i].want : p);
    end

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      in_valid <= 1'b0;
      wait_drained();
      case (ph)
        0: ;
        1: begin
          write_reg(REG_DEBOUNCE, 14'd0);
          write_reg(REG_LONG_PRESS, 14'd100);
        end
        2: begin
          write_reg(REG_DEBOUNCE, 14'd1000);
          write_reg(REG_LONG_PRESS, 14'd10000);
        end
        3: begin
          write_reg(REG_DEBOUNCE, 14'd1001);
          write_reg(REG_LONG_PRESS, 14'd99);
          write_reg(REG_LONG_PRESS, 14'd10001);
          write_reg(REG_SPARE_A, 14'h3FFF);
          write_reg(REG_SPARE_B, 14'h3FFF);
          write_reg(REG_DEBOUNCE, 14'h3FFF);
          write_reg(REG_LONG_PRESS, 14'h3FFF);
          write_reg(REG_DEBOUNCE, 14'h2005);
        end
        4: begin
          write_reg(REG_DEBOUNCE, 14'd50);
          write_reg(REG_LONG_PRESS, 14'd300);
        end
        5: begin
          write_reg(REG_DEBOUNCE, 14'd7);
          write_reg(REG_LONG_PRESS, 14'd150);
        end
        6: begin
          write_reg(REG_DEBOUNCE, 14'($urandom_range(0, 1000)));
          write_reg(REG_LONG_PRESS, 14'($urandom_range(100, 10000)));
        end
        default: begin
          write_reg(REG_DEBOUNCE, 14'd20);
          write_reg(REG_LONG_PRESS, 14'd1000);
        end
      endcase
      cfg_valid <= 1'b0;

      case (ph % 4)
        0: begin snd_pct = 0;  rcv_pct = 0;  end
        1: begin snd_pct = 48; rcv_pct = 0;  end
        2: begin snd_pct = 0;  rcv_pct = 48; end
        default: begin snd_pct = 22; rcv_pct = 22; end
      endcase
      pop_pct = (ph == 5) ? 5 : (ph == 7) ? 50 : 28;
      if (ph == 3) t = 32'hFFFF_F000;
      if (ph == 6) t = $urandom;
      phase_no = ph;

      n = 0;
      while (n < PHASE_WORDS) begin
        r = $urandom_range(0, 99);
        if (r < pop_pct + 6) begin
          w.action        = (r < pop_pct) ? ACT_POP : ACT_SAMPLE;
          w.key_row       = 2'($urandom_range(0, 3));
          w.key_col       = 2'($urandom_range(0, 3));
          w.level_pressed = 1'($urandom_range(0, 1));
          w.now_ms        = $urandom;
          send_word(w, p);
          due_words.push_back(p);
          n++;
        end else begin
          kk  = 4'($urandom_range(0, NUM_KEYS - 1));
          lvl = ($urandom_range(0, 99) < 80) ? (key_st[kk] == KS_RELEASED)
                                             : 1'($urandom_range(0, 1));
          len = ($urandom_range(0, 99) < 15) ? $urandom_range(10, 20) : $urandom_range(1, 6);
          r   = $urandom_range(0, 99);
          step_max = (r < 15) ? 2 : (r < 60) ? int'(db_ms) / 2 + 3 : int'(lp_ms) / 3 + 1;
          repeat (len) begin
            t = t + $urandom_range(0, step_max);
            w.action        = ACT_SAMPLE;
            w.key_row       = kk[3:2];
            w.key_col       = kk[1:0];
            w.level_pressed = lvl;
            w.now_ms        = t;
            send_word(w, p);
            due_words.push_back(p);
            n++;
          end
        end
      end
    end

    in_valid <= 1'b0;
    wait_drained();
    repeat (8) @(posedge clk);
    if (err_cnt == 0 && due_words.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
